// File: hw/rtl/ppr_pkg.sv
// Shared types, constants and helpers for the pose-to-roll/pitch/yaw block.
// Depends on nothing; used by every module under hw/rtl.
`timescale 1ns / 1ps

package ppr_pkg;

    localparam int CORDIC_STAGES = 24;
    // Datapath width: Q2.28 entries plus CORDIC gain headroom
    localparam int CW = 34;
    localparam int PIPE_DEPTH = CORDIC_STAGES + 1;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032875;
    localparam logic [31:0] QUARTER_POS = 32'h4000_0000;
    localparam logic [31:0] QUARTER_NEG = 32'hC000_0000;

    typedef logic signed [CW-1:0] cord_t;

    typedef struct packed {
        logic signed [15:0] rot_00;
        logic signed [15:0] rot_10;
        logic signed [15:0] rot_20;
        logic signed [15:0] rot_21;
        logic signed [15:0] rot_22;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] pos_z_in;
    } pose_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] pos_z_out;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } pose_out_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    // atan(2^-i), 2^32 per full turn
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        v = 32'h0;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Q2.14 to Q2.28, sign-extended to the datapath width
    function automatic cord_t widen(input logic signed [15:0] r);
        return cord_t'({{(CW-30){r[15]}}, r, 14'b0});
    endfunction

    // 32-bit angle to 16-bit binary angle, round half up, wrapping
    function automatic logic signed [15:0] bam16(input logic [31:0] z);
        logic [31:0] s;
        s = z + 32'h0000_8000;
        return s[31:16];
    endfunction

endpackage

// File: hw/rtl/ppr_vec_cordic.sv
// Pipelined vectoring CORDIC: quadrant pre-rotation plus one register per micro-rotation.
// Depends on ppr_pkg. Every register advances only while en is high.
`timescale 1ns / 1ps

module ppr_vec_cordic
    import ppr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  cord_t       x_in,
    input  cord_t       y_in,
    output cord_t       x_out,
    output logic [31:0] z_out
);

    cord_t       x_reg [0:CORDIC_STAGES];
    cord_t       y_reg [0:CORDIC_STAGES];
    logic [31:0] z_reg [0:CORDIC_STAGES];

    cord_t       x_next;
    cord_t       y_next;
    logic [31:0] z_next;

    // Quarter-turn pre-rotation into the right half plane
    always_comb
    begin
        x_next = x_in;
        y_next = y_in;
        z_next = 32'h0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_next = y_in;
                y_next = -x_in;
                z_next = QUARTER_POS;
            end
            else
            begin
                x_next = -y_in;
                y_next = x_in;
                z_next = QUARTER_NEG;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x_next;
            y_reg[0] <= y_next;
            z_reg[0] <= z_next;
        end
    end

    // One micro-rotation per stage; y == 0 holds the vector
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
                else if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i];
                    y_reg[i+1] <= y_reg[i];
                    z_reg[i+1] <= z_reg[i];
                end
            end
        end
    end

    assign x_out = x_reg[CORDIC_STAGES];
    assign z_out = z_reg[CORDIC_STAGES];

endmodule

// File: hw/rtl/pose_matrix_to_roll_pitch_yaw_core.sv
// Top level: pose matrix entries to roll, pitch, yaw with translation pass-through.
// Depends on ppr_pkg and ppr_vec_cordic.
`timescale 1ns / 1ps

// Usage
//   Input channel in_valid/in_ready/in_data carries one pose beat (five Q2.14
//   rotation entries, Q16.16 translation). Output channel out_valid/out_ready/
//   out_data carries one beat per pose: translation unchanged, roll, pitch and
//   yaw as 16-bit binary angles (32768 is pi).
//   Roll and yaw run in two parallel 25-stage vectoring CORDICs; a 32x30
//   multiply removes the CORDIC gain from the yaw vector length; a third
//   25-stage CORDIC gives pitch; a final register rounds and presents results.
//   Throughput: one beat per cycle when the receiver does not stall, set by
//   the one-rotation-per-stage CORDICs.
//   When the receiver stalls with a result pending, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated. in_ready is high whenever
//   the output register is empty or being taken.
//   Reset (rst_n low, asynchronous) clears all valid bits; the pipeline is
//   empty and ready right after reset.
module pose_matrix_to_roll_pitch_yaw_core
    import ppr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pose_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pose_out_t out_data
);

    logic en;

    // Pipeline advances whenever the output register can take a beat
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- roll / yaw phase ----------------
    cord_t       roll_len;
    cord_t       yaw_len;
    logic [31:0] roll_z;
    logic [31:0] yaw_z;

    ppr_vec_cordic u_roll (
        .clk   (clk),
        .en    (en),
        .x_in  (widen(in_data.rot_22)),
        .y_in  (widen(in_data.rot_21)),
        .x_out (roll_len),
        .z_out (roll_z)
    );

    ppr_vec_cordic u_yaw (
        .clk   (clk),
        .en    (en),
        .x_in  (widen(in_data.rot_00)),
        .y_in  (widen(in_data.rot_10)),
        .x_out (yaw_len),
        .z_out (yaw_z)
    );

    logic               vld_a_reg [0:PIPE_DEPTH-1];
    pos_t               pos_a_reg [0:PIPE_DEPTH-1];
    logic signed [15:0] r20_a_reg [0:PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                vld_a_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_a_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                vld_a_reg[k] <= vld_a_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_a_reg[0] <= '{x: in_data.pos_x_in, y: in_data.pos_y_in,
                               z: in_data.pos_z_in};
            r20_a_reg[0] <= in_data.rot_20;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                pos_a_reg[k] <= pos_a_reg[k-1];
                r20_a_reg[k] <= r20_a_reg[k-1];
            end
        end
    end

    // ---------------- gain removal ----------------
    // yaw length is non-negative and below 2^31, so 32 bits carry it
    logic [61:0] dot_prod;
    assign dot_prod = yaw_len[31:0] * INV_GAIN_Q30;

    logic               vld_m_reg;
    cord_t              dot_reg;
    cord_t              negr20_reg;
    pos_t               pos_m_reg;
    logic signed [15:0] roll_m_reg;
    logic signed [15:0] yaw_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_m_reg <= vld_a_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg    <= cord_t'({{(CW-32){1'b0}}, dot_prod[61:30]});
            negr20_reg <= cord_t'(0) - widen(r20_a_reg[PIPE_DEPTH-1]);
            pos_m_reg  <= pos_a_reg[PIPE_DEPTH-1];
            roll_m_reg <= bam16(roll_z);
            yaw_m_reg  <= bam16(yaw_z);
        end
    end

    // ---------------- pitch phase ----------------
    cord_t       pitch_len;
    logic [31:0] pitch_z;

    ppr_vec_cordic u_pitch (
        .clk   (clk),
        .en    (en),
        .x_in  (dot_reg),
        .y_in  (negr20_reg),
        .x_out (pitch_len),
        .z_out (pitch_z)
    );

    logic               vld_b_reg  [0:PIPE_DEPTH-1];
    pos_t               pos_b_reg  [0:PIPE_DEPTH-1];
    logic signed [15:0] roll_b_reg [0:PIPE_DEPTH-1];
    logic signed [15:0] yaw_b_reg  [0:PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PIPE_DEPTH; k++)
            begin
                vld_b_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_b_reg[0] <= vld_m_reg;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                vld_b_reg[k] <= vld_b_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_b_reg[0]  <= pos_m_reg;
            roll_b_reg[0] <= roll_m_reg;
            yaw_b_reg[0]  <= yaw_m_reg;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                pos_b_reg[k]  <= pos_b_reg[k-1];
                roll_b_reg[k] <= roll_b_reg[k-1];
                yaw_b_reg[k]  <= yaw_b_reg[k-1];
            end
        end
    end

    // ---------------- output register ----------------
    pose_out_t out_data_reg;
    pose_out_t out_data_next;

    always_comb
    begin
        out_data_next.pos_x_out = pos_b_reg[PIPE_DEPTH-1].x;
        out_data_next.pos_y_out = pos_b_reg[PIPE_DEPTH-1].y;
        out_data_next.pos_z_out = pos_b_reg[PIPE_DEPTH-1].z;
        out_data_next.roll      = roll_b_reg[PIPE_DEPTH-1];
        out_data_next.pitch     = bam16(pitch_z);
        out_data_next.yaw       = yaw_b_reg[PIPE_DEPTH-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_b_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // vector lengths of roll and pitch are not needed
    logic unused_len;
    assign unused_len = ^{roll_len, pitch_len};

endmodule

// File: hw/rtl/ppr_checker.sv
// Port-level checks for pose_matrix_to_roll_pitch_yaw_core, attached by bind.
// Depends on ppr_pkg.
`timescale 1ns / 1ps

module ppr_checker
    import ppr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input pose_in_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input pose_out_t out_data
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Input side is open whenever the output can drain
    a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("in_ready low with free output");

    // Input side closes exactly when a result is stalled
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("in_ready high during output stall");

    // The pipeline holds while stalled: a pending result stays valid and is not lost
    a_no_beat_from_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> out_valid)
        else $error("result lost during stall");

    logic unused_in;
    assign unused_in = ^{in_valid, in_data};

endmodule

bind pose_matrix_to_roll_pitch_yaw_core ppr_checker u_ppr_checker (.*);
